>>> src/acio_pkg.sv
// ----------------------------------------------------------------------------
// acio_pkg
// Shared types and codes for the sound coprocessor I/O register window.
// ----------------------------------------------------------------------------
package acio_pkg;

  localparam int unsigned ActionW = 3;
  localparam int unsigned OffsetW = 4;
  localparam int unsigned PortW   = 2;
  localparam int unsigned TselW   = 2;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned DidxW   = 7;
  localparam int unsigned NTimers = 3;
  localparam int unsigned NPorts  = 4;
  localparam int unsigned NAux    = 2;
  localparam int unsigned TOutW   = 4;

  // bus actions
  localparam logic [ActionW-1:0] ACT_IO_READ    = 3'd0;
  localparam logic [ActionW-1:0] ACT_IO_WRITE   = 3'd1;
  localparam logic [ActionW-1:0] ACT_HOST_READ  = 3'd2;
  localparam logic [ActionW-1:0] ACT_HOST_WRITE = 3'd3;
  localparam logic [ActionW-1:0] ACT_TOUT_LOAD  = 3'd4;

  // register offsets within the 0xf0-0xff window
  localparam logic [OffsetW-1:0] OFF_TEST       = 4'd0;
  localparam logic [OffsetW-1:0] OFF_CONTROL    = 4'd1;
  localparam logic [OffsetW-1:0] OFF_DSPADDR    = 4'd2;
  localparam logic [OffsetW-1:0] OFF_DSPDATA    = 4'd3;
  localparam logic [OffsetW-1:0] OFF_PORT_FIRST = 4'd4;
  localparam logic [OffsetW-1:0] OFF_PORT_LAST  = 4'd7;
  localparam logic [OffsetW-1:0] OFF_AUX_FIRST  = 4'd8;
  localparam logic [OffsetW-1:0] OFF_AUX_LAST   = 4'd9;
  localparam logic [OffsetW-1:0] OFF_TGT_FIRST  = 4'd10;
  localparam logic [OffsetW-1:0] OFF_TGT_LAST   = 4'd12;
  localparam logic [OffsetW-1:0] OFF_TOUT_FIRST = 4'd13;
  localparam logic [OffsetW-1:0] OFF_TOUT_LAST  = 4'd15;

  // CONTROL bit positions
  localparam int unsigned CTL_CLR_PORTS01 = 4;
  localparam int unsigned CTL_CLR_PORTS23 = 5;
  localparam int unsigned CTL_ROM_EN      = 7;

  // DSP address bit that makes the upper half read-only
  localparam int unsigned DSP_RO_BIT = 7;

  typedef struct packed {
    logic [ActionW-1:0] action;
    logic [OffsetW-1:0] reg_offset;
    logic [PortW-1:0]   port_index;
    logic [ByteW-1:0]   write_data;
    logic               p_flag;
    logic [ByteW-1:0]   dsp_data_in;
    logic [TselW-1:0]   timer_select;
  } req_t;

  typedef struct packed {
    logic [ByteW-1:0]   read_data;
    logic               dsp_read;
    logic               dsp_write;
    logic [DidxW-1:0]   dsp_index;
    logic [ByteW-1:0]   dsp_write_data;
    logic [NTimers-1:0] timer_enable_mask;
    logic [NTimers-1:0] timer_restart_mask;
    logic [ByteW-1:0]   test_bits;
    logic               rom_enable;
    logic               stage_resync;
  } rsp_t;

endpackage

>>> src/acio_if.sv
// ----------------------------------------------------------------------------
// acio_req_if / acio_rsp_if
// Valid/ready channels for bus requests and their results.
// ----------------------------------------------------------------------------
interface acio_req_if;
  logic                          valid;
  logic                          ready;
  logic [acio_pkg::ActionW-1:0]  action;
  logic [acio_pkg::OffsetW-1:0]  reg_offset;
  logic [acio_pkg::PortW-1:0]    port_index;
  logic [acio_pkg::ByteW-1:0]    write_data;
  logic                          p_flag;
  logic [acio_pkg::ByteW-1:0]    dsp_data_in;
  logic [acio_pkg::TselW-1:0]    timer_select;

  modport source (output valid, action, reg_offset, port_index, write_data, p_flag,
                  dsp_data_in, timer_select, input ready);
  modport sink (input valid, action, reg_offset, port_index, write_data, p_flag,
                dsp_data_in, timer_select, output ready);
endinterface

interface acio_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [acio_pkg::ByteW-1:0]    read_data;
  logic                          dsp_read;
  logic                          dsp_write;
  logic [acio_pkg::DidxW-1:0]    dsp_index;
  logic [acio_pkg::ByteW-1:0]    dsp_write_data;
  logic [acio_pkg::NTimers-1:0]  timer_enable_mask;
  logic [acio_pkg::NTimers-1:0]  timer_restart_mask;
  logic [acio_pkg::ByteW-1:0]    test_bits;
  logic                          rom_enable;
  logic                          stage_resync;

  modport source (output valid, read_data, dsp_read, dsp_write, dsp_index, dsp_write_data,
                  timer_enable_mask, timer_restart_mask, test_bits, rom_enable,
                  stage_resync, input ready);
  modport sink (input valid, read_data, dsp_read, dsp_write, dsp_index, dsp_write_data,
                timer_enable_mask, timer_restart_mask, test_bits, rom_enable,
                stage_resync, output ready);
endinterface

>>> src/audio_cpu_io_register_block_core.sv
// ----------------------------------------------------------------------------
// audio_cpu_io_register_block_core
// I/O register window 0xf0-0xff of a sound coprocessor with host mailbox.
// ----------------------------------------------------------------------------
//  channel | dir | contents
//  req     | in  | one bus request: action, offset, port, data, P flag, DSP byte, timer select
//  rsp     | out | one result per request: read data, DSP strobes, status
//
//  Every request passes an input register and a result register; one request
//  per cycle is sustained while the result is accepted. Register state is
//  updated as a request moves from the input register into the result register.
//  A stalled result holds both stages; the input register still takes a request
//  while it is empty. Reset clears valid flags and register state to zero.
// ----------------------------------------------------------------------------
module audio_cpu_io_register_block_core (
  input  logic       clk,
  input  logic       rst,
  acio_req_if.sink   req,
  acio_rsp_if.source rsp
);

  // input stage
  logic           s1_valid;
  acio_pkg::req_t s1;
  logic           s1_adv;
  logic           fire;

  // result stage
  logic           res_valid;
  acio_pkg::rsp_t res;
  acio_pkg::rsp_t res_next;

  // register state
  logic [acio_pkg::ByteW-1:0]   test_reg, test_reg_next;
  logic [acio_pkg::NTimers-1:0] timer_enables, timer_enables_next;
  logic [acio_pkg::ByteW-1:0]   timer_targets [acio_pkg::NTimers];
  logic [acio_pkg::ByteW-1:0]   timer_targets_next [acio_pkg::NTimers];
  logic [acio_pkg::TOutW-1:0]   timer_outputs [acio_pkg::NTimers];
  logic [acio_pkg::TOutW-1:0]   timer_outputs_next [acio_pkg::NTimers];
  logic [acio_pkg::ByteW-1:0]   h2c_ports [acio_pkg::NPorts];
  logic [acio_pkg::ByteW-1:0]   h2c_ports_next [acio_pkg::NPorts];
  logic [acio_pkg::ByteW-1:0]   c2h_ports [acio_pkg::NPorts];
  logic [acio_pkg::ByteW-1:0]   c2h_ports_next [acio_pkg::NPorts];
  logic [acio_pkg::ByteW-1:0]   aux_bytes [acio_pkg::NAux];
  logic [acio_pkg::ByteW-1:0]   aux_bytes_next [acio_pkg::NAux];
  logic [acio_pkg::ByteW-1:0]   dsp_address, dsp_address_next;
  logic                         boot_rom_enable, boot_rom_enable_next;

  logic [acio_pkg::NTimers-1:0] rise;
  logic [1:0]                   tgt_idx;
  logic [1:0]                   tout_idx;
  logic [acio_pkg::OffsetW-1:0] tgt_diff;
  logic [acio_pkg::OffsetW-1:0] tout_diff;

  assign s1_adv    = !res_valid || rsp.ready;
  assign fire      = s1_valid && s1_adv;
  assign req.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
    if (req.valid && req.ready) begin
      s1.action       <= req.action;
      s1.reg_offset   <= req.reg_offset;
      s1.port_index   <= req.port_index;
      s1.write_data   <= req.write_data;
      s1.p_flag       <= req.p_flag;
      s1.dsp_data_in  <= req.dsp_data_in;
      s1.timer_select <= req.timer_select;
    end
  end

  assign tgt_diff  = s1.reg_offset - acio_pkg::OFF_TGT_FIRST;
  assign tout_diff = s1.reg_offset - acio_pkg::OFF_TOUT_FIRST;
  assign tgt_idx   = tgt_diff[1:0];
  assign tout_idx  = tout_diff[1:0];
  assign rise      = s1.write_data[acio_pkg::NTimers-1:0] & ~timer_enables;

  always_comb begin
    test_reg_next        = test_reg;
    timer_enables_next   = timer_enables;
    timer_targets_next   = timer_targets;
    timer_outputs_next   = timer_outputs;
    h2c_ports_next       = h2c_ports;
    c2h_ports_next       = c2h_ports;
    aux_bytes_next       = aux_bytes;
    dsp_address_next     = dsp_address;
    boot_rom_enable_next = boot_rom_enable;
    res_next             = '0;

    case (s1.action)
      acio_pkg::ACT_IO_READ: begin
        case (s1.reg_offset) inside
          acio_pkg::OFF_DSPADDR: res_next.read_data = dsp_address;
          acio_pkg::OFF_DSPDATA: begin
            res_next.dsp_read  = 1'b1;
            res_next.dsp_index = dsp_address[acio_pkg::DidxW-1:0];
            res_next.read_data = s1.dsp_data_in;
          end
          [acio_pkg::OFF_PORT_FIRST:acio_pkg::OFF_PORT_LAST]:
            res_next.read_data = h2c_ports[s1.reg_offset[1:0]];
          [acio_pkg::OFF_AUX_FIRST:acio_pkg::OFF_AUX_LAST]:
            res_next.read_data = aux_bytes[s1.reg_offset[0]];
          [acio_pkg::OFF_TOUT_FIRST:acio_pkg::OFF_TOUT_LAST]: begin
            // timer outputs clear on read
            res_next.read_data = {{(acio_pkg::ByteW-acio_pkg::TOutW){1'b0}},
                                  timer_outputs[tout_idx]};
            timer_outputs_next[tout_idx] = '0;
          end
          default: res_next.read_data = '0;
        endcase
      end
      acio_pkg::ACT_IO_WRITE: begin
        case (s1.reg_offset) inside
          acio_pkg::OFF_TEST: begin
            if (!s1.p_flag) begin
              test_reg_next         = s1.write_data;
              res_next.stage_resync = 1'b1;
            end
          end
          acio_pkg::OFF_CONTROL: begin
            for (int t = 0; t < acio_pkg::NTimers; t++) begin
              if (rise[t]) timer_outputs_next[t] = '0;
            end
            timer_enables_next          = s1.write_data[acio_pkg::NTimers-1:0];
            res_next.timer_restart_mask = rise;
            if (s1.write_data[acio_pkg::CTL_CLR_PORTS01]) begin
              h2c_ports_next[0] = '0;
              h2c_ports_next[1] = '0;
            end
            if (s1.write_data[acio_pkg::CTL_CLR_PORTS23]) begin
              h2c_ports_next[2] = '0;
              h2c_ports_next[3] = '0;
            end
            boot_rom_enable_next = s1.write_data[acio_pkg::CTL_ROM_EN];
          end
          acio_pkg::OFF_DSPADDR: dsp_address_next = s1.write_data;
          acio_pkg::OFF_DSPDATA: begin
            // upper half of the DSP space is a read-only mirror
            if (!dsp_address[acio_pkg::DSP_RO_BIT]) begin
              res_next.dsp_write      = 1'b1;
              res_next.dsp_index      = dsp_address[acio_pkg::DidxW-1:0];
              res_next.dsp_write_data = s1.write_data;
            end
          end
          [acio_pkg::OFF_PORT_FIRST:acio_pkg::OFF_PORT_LAST]:
            c2h_ports_next[s1.reg_offset[1:0]] = s1.write_data;
          [acio_pkg::OFF_AUX_FIRST:acio_pkg::OFF_AUX_LAST]:
            aux_bytes_next[s1.reg_offset[0]] = s1.write_data;
          [acio_pkg::OFF_TGT_FIRST:acio_pkg::OFF_TGT_LAST]:
            timer_targets_next[tgt_idx] = s1.write_data;
          default: ;
        endcase
      end
      acio_pkg::ACT_HOST_READ:  res_next.read_data = c2h_ports[s1.port_index];
      acio_pkg::ACT_HOST_WRITE: h2c_ports_next[s1.port_index] = s1.write_data;
      acio_pkg::ACT_TOUT_LOAD: begin
        if (s1.timer_select < 2'(acio_pkg::NTimers)) begin
          timer_outputs_next[s1.timer_select] = s1.write_data[acio_pkg::TOutW-1:0];
        end
      end
      default: ;
    endcase

    res_next.timer_enable_mask = timer_enables_next;
    res_next.test_bits         = test_reg_next;
    res_next.rom_enable        = boot_rom_enable_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid       <= 1'b0;
      test_reg        <= '0;
      timer_enables   <= '0;
      dsp_address     <= '0;
      boot_rom_enable <= 1'b0;
      for (int i = 0; i < acio_pkg::NTimers; i++) begin
        timer_targets[i] <= '0;
        timer_outputs[i] <= '0;
      end
      for (int i = 0; i < acio_pkg::NPorts; i++) begin
        h2c_ports[i] <= '0;
        c2h_ports[i] <= '0;
      end
      for (int i = 0; i < acio_pkg::NAux; i++) begin
        aux_bytes[i] <= '0;
      end
    end else begin
      if (s1_adv) begin
        res_valid <= s1_valid;
      end
      if (fire) begin
        test_reg        <= test_reg_next;
        timer_enables   <= timer_enables_next;
        timer_targets   <= timer_targets_next;
        timer_outputs   <= timer_outputs_next;
        h2c_ports       <= h2c_ports_next;
        c2h_ports       <= c2h_ports_next;
        aux_bytes       <= aux_bytes_next;
        dsp_address     <= dsp_address_next;
        boot_rom_enable <= boot_rom_enable_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res <= res_next;
    end
  end

  assign rsp.valid              = res_valid;
  assign rsp.read_data          = res.read_data;
  assign rsp.dsp_read           = res.dsp_read;
  assign rsp.dsp_write          = res.dsp_write;
  assign rsp.dsp_index          = res.dsp_index;
  assign rsp.dsp_write_data     = res.dsp_write_data;
  assign rsp.timer_enable_mask  = res.timer_enable_mask;
  assign rsp.timer_restart_mask = res.timer_restart_mask;
  assign rsp.test_bits          = res.test_bits;
  assign rsp.rom_enable         = res.rom_enable;
  assign rsp.stage_resync       = res.stage_resync;

`ifndef SYNTHESIS
  a_dsp_one_dir: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.dsp_read && res.dsp_write))
    else $error("DSP read and write issued together");

  a_restart_enabled: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> ((res.timer_restart_mask & ~res.timer_enable_mask) == '0))
    else $error("restart on a timer that is not enabled");

  a_dsp_data_gated: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.dsp_write) |-> (res.dsp_write_data == '0))
    else $error("DSP write data without a DSP write");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !$past(fire) && !$past(rst) |-> $stable(test_reg) && $stable(dsp_address))
    else $error("register state changed without a request");
`endif

endmodule
